// ===== hw/rtl/llab_pkg.sv =====
// Shared types and constants for the light level average bar block.
// Holds field widths, register indexes, reset values and the LED bar encoding.
// No dependencies.
`default_nettype none

package llab_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned FIELD_W     = 10;
  localparam int unsigned DIV_W       = 8;
  localparam int unsigned LIMIT_W     = 10;
  localparam int unsigned LIT_W       = 2;
  localparam int unsigned PIN_W       = 3;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  // Defaults for the top-level parameters.
  localparam int unsigned WINDOW_DEF      = 4;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_DIVIDER = 2'd0,
    REG_THREE_LIT    = 2'd1,
    REG_TWO_LIT      = 2'd2,
    REG_ONE_LIT      = 2'd3
  } cfg_reg_t;

  localparam logic [DIV_W-1:0]   TICK_DIVIDER_RST = 8'd5;
  localparam logic [LIMIT_W-1:0] THREE_LIT_RST    = 10'd300;
  localparam logic [LIMIT_W-1:0] TWO_LIT_RST      = 10'd400;
  localparam logic [LIMIT_W-1:0] ONE_LIT_RST      = 10'd500;

  // Active-low pin patterns, bit 0 is the first LED.
  localparam logic [PIN_W-1:0] PINS_THREE = 3'b000;
  localparam logic [PIN_W-1:0] PINS_TWO   = 3'b100;
  localparam logic [PIN_W-1:0] PINS_ONE   = 3'b110;
  localparam logic [PIN_W-1:0] PINS_NONE  = 3'b111;

  typedef struct packed {
    logic le_three;
    logic le_two;
    logic le_one;
  } limit_hits_t;

  typedef struct packed {
    logic [LIT_W-1:0] lit;
    logic [PIN_W-1:0] pins;
  } bar_t;

  // The first limit met, checked from three LEDs down, decides the bar.
  function automatic bar_t bar_from_hits(limit_hits_t hits);
    bar_t b;
    if (hits.le_three) begin
      b.lit  = 2'd3;
      b.pins = PINS_THREE;
    end else if (hits.le_two) begin
      b.lit  = 2'd2;
      b.pins = PINS_TWO;
    end else if (hits.le_one) begin
      b.lit  = 2'd1;
      b.pins = PINS_ONE;
    end else begin
      b.lit  = 2'd0;
      b.pins = PINS_NONE;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/llab_cell.sv =====
// One stage of the sample window shift line.
// Holds one sample and passes it on to its neighbor when the window shifts.
// Does not depend on llab_pkg or any other file.
`default_nettype none

module llab_cell #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   shift_en,
  input  wire logic [SAMPLE_BITS-1:0] d_in,
  output logic      [SAMPLE_BITS-1:0] q_out
);

  logic [SAMPLE_BITS-1:0] smp_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      smp_r <= d_in;
    end
  end

  assign q_out = smp_r;

endmodule

`default_nettype wire

// ===== hw/rtl/llab_window.sv =====
// Sliding sample window: a chain of llab_cell stages with a fill counter
// and a running sum. Depends on llab_cell.
`default_nettype none

module llab_window #(
  parameter int unsigned WINDOW      = 4,
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   take,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic      [SUM_W-1:0]       sum_nxt,
  output logic                        full
);

  localparam int unsigned FILL_W = $clog2(WINDOW + 1);

  logic [SAMPLE_BITS-1:0] tap [WINDOW];
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      fill_nxt;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       oldest;

  // New samples enter at the far end; the oldest sits in the first cell.
  for (genvar k = 0; k < WINDOW; k++) begin : g_chain
    if (k == WINDOW - 1) begin : g_tail
      llab_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk     (clk),
        .shift_en(take),
        .d_in    (sample),
        .q_out   (tap[k])
      );
    end else begin : g_body
      llab_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk     (clk),
        .shift_en(take),
        .d_in    (tap[k+1]),
        .q_out   (tap[k])
      );
    end
  end

  assign full     = (fill_r == FILL_W'(WINDOW));
  assign oldest   = full ? SUM_W'(tap[0]) : '0;
  assign sum_nxt  = sum_r + SUM_W'(sample) - oldest;
  assign fill_nxt = full ? fill_r : fill_r + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else if (take) begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("window fill count ran past the window depth");

  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> full)
    else $error("window lost its full state without a reset");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/light_level_average_bar.sv =====
// Light level average bar, top level.
// Channels: in_* carries one timer tick per transaction with the sensor
// conversion in in_tdata; out_* carries one result per taken sample; cfg_*
// writes the divider and the three limits and is always ready.
// Every tick_divider-th tick (256 when the divider is zero) the sample goes
// into a WINDOW-deep shift window with a running sum. Once the window is
// full, each taken sample updates the held average, which is compared with
// the limits to give the lit-LED count and active-low pin pattern.
// Throughput: one tick per cycle while in_tready is high. A result passes
// through three registered stages: window update, then the reciprocal
// multiply for the average, then the limit compare.
// Reset clears the tick and fill counters, the running sum and the held
// average, restores the register defaults and empties the pipeline.
// When the receiver stalls, results back up through the three stages and
// in_tready falls only once all of them hold a result; ticks that take no
// sample still need a free first stage to be accepted.
// Depends on llab_pkg and llab_window.
`default_nettype none

module light_level_average_bar
  import llab_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] adc_sample
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [9:0] taken_sample, [19:10] window_average, [21:20] lit_count, [24:22] led_pins
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned LOG_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W  = SAMPLE_BITS + LOG_W;
  localparam int unsigned SHIFT  = SUM_W + LOG_W;
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  localparam int unsigned CMP_W  = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
  localparam int unsigned EXT_W  = SAMPLE_BITS + FIELD_W;
  // Rounded-up reciprocal of WINDOW; exact floor division for any sum value.
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Configuration registers.
  logic [DIV_W-1:0]   div_r;
  logic [LIMIT_W-1:0] three_r;
  logic [LIMIT_W-1:0] two_r;
  logic [LIMIT_W-1:0] one_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= TICK_DIVIDER_RST;
      three_r <= THREE_LIT_RST;
      two_r   <= TWO_LIT_RST;
      one_r   <= ONE_LIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TICK_DIVIDER: div_r   <= cfg_data[DIV_W-1:0];
        REG_THREE_LIT:    three_r <= cfg_data[LIMIT_W-1:0];
        REG_TWO_LIT:      two_r   <= cfg_data[LIMIT_W-1:0];
        REG_ONE_LIT:      one_r   <= cfg_data[LIMIT_W-1:0];
        default:          div_r   <= div_r;
      endcase
    end
  end

  // Pipeline handshake.
  logic s1_v_r, s2_v_r, out_v_r;
  logic adv_out, mv2, rdy2, mv1;
  logic acc, take;

  assign adv_out   = !out_v_r || out_tready;
  assign mv2       = s2_v_r && adv_out;
  assign rdy2      = !s2_v_r || adv_out;
  assign mv1       = s1_v_r && rdy2;
  assign in_tready = !s1_v_r || rdy2;
  assign acc       = in_tvalid && in_tready;

  // Tick divider.
  logic [DIV_W-1:0] tick_r;
  logic [DIV_W:0]   period;
  logic [DIV_W:0]   tick_next;

  assign period    = (div_r == '0) ? (DIV_W+1)'(1 << DIV_W) : {1'b0, div_r};
  assign tick_next = {1'b0, tick_r} + (DIV_W+1)'(1);
  assign take      = (tick_next >= period);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (acc) begin
      tick_r <= take ? '0 : tick_next[DIV_W-1:0];
    end
  end

  // Sample narrowed or widened to the configured sample width.
  logic [EXT_W-1:0]       in_ext;
  logic [SAMPLE_BITS-1:0] sample;

  assign in_ext = {{SAMPLE_BITS{1'b0}}, in_tdata[FIELD_W-1:0]};
  assign sample = in_ext[SAMPLE_BITS-1:0];

  // Stage 1: window and running sum update.
  logic [SUM_W-1:0]       win_sum;
  logic                   win_full;
  logic [SAMPLE_BITS-1:0] s1_smp_r;
  logic [SUM_W-1:0]       s1_sum_r;
  logic                   s1_upd_r;

  llab_window #(
    .WINDOW     (WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (acc && take),
    .sample (sample),
    .sum_nxt(win_sum),
    .full   (win_full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc && take) begin
      s1_v_r <= 1'b1;
    end else if (mv1) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && take) begin
      s1_smp_r <= sample;
      s1_sum_r <= win_sum;
      s1_upd_r <= win_full;
    end
  end

  // Stage 2: average by reciprocal multiply, held between updates.
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] avg_calc;
  logic [SAMPLE_BITS-1:0] avg_nxt;
  logic [SAMPLE_BITS-1:0] held_avg_r;
  logic [SAMPLE_BITS-1:0] s2_smp_r;
  logic [SAMPLE_BITS-1:0] s2_avg_r;

  assign prod     = PROD_W'(s1_sum_r) * PROD_W'(RECIP);
  assign avg_calc = prod[SHIFT +: SAMPLE_BITS];
  assign avg_nxt  = s1_upd_r ? avg_calc : held_avg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r     <= 1'b0;
      held_avg_r <= '0;
    end else begin
      if (mv1) begin
        s2_v_r     <= 1'b1;
        held_avg_r <= avg_nxt;
      end else if (mv2) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_smp_r <= s1_smp_r;
      s2_avg_r <= avg_nxt;
    end
  end

  // Stage 3: limit compare into the output register.
  limit_hits_t            hits;
  bar_t                   bar;
  logic [EXT_W-1:0]       smp_ext;
  logic [EXT_W-1:0]       avg_ext;
  logic [FIELD_W-1:0]     out_smp_r;
  logic [FIELD_W-1:0]     out_avg_r;
  bar_t                   out_bar_r;

  assign hits.le_three = (CMP_W'(s2_avg_r) <= CMP_W'(three_r));
  assign hits.le_two   = (CMP_W'(s2_avg_r) <= CMP_W'(two_r));
  assign hits.le_one   = (CMP_W'(s2_avg_r) <= CMP_W'(one_r));
  assign bar           = bar_from_hits(hits);
  assign smp_ext       = {{FIELD_W{1'b0}}, s2_smp_r};
  assign avg_ext       = {{FIELD_W{1'b0}}, s2_avg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (mv2) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      out_smp_r <= smp_ext[FIELD_W-1:0];
      out_avg_r <= avg_ext[FIELD_W-1:0];
      out_bar_r <= bar;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {
    (OUT_TDATA_W - 2 * FIELD_W - LIT_W - PIN_W)'(0),
    out_bar_r.pins, out_bar_r.lit, out_avg_r, out_smp_r
  };

`ifndef NO_ASSERTIONS
  a_held_avg_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(mv1 && s1_upd_r) |=> $stable(held_avg_r))
    else $error("held average changed without a full-window sample");

  a_tick_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !take) |=> (tick_r == $past(tick_r) + DIV_W'(1)))
    else $error("tick counter did not advance on a skipped tick");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !mv2) |=> (s2_v_r && $stable(s2_avg_r) && $stable(s2_smp_r)))
    else $error("stage two result lost while the output was stalled");
`endif

endmodule

`default_nettype wire
